// ===== rtl/ts_pcr_bitrate_estimator_core_macros.svh =====
// assertion macros shared by the pcr bitrate estimator rtl
// no dependencies; taken in by the modules that carry assertions
`ifndef TS_PCR_BITRATE_ESTIMATOR_CORE_MACROS_SVH
`define TS_PCR_BITRATE_ESTIMATOR_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define TS_PBE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ts_pbe assertion failed");

// next-cycle implication, disabled while reset is low
`define TS_PBE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ts_pbe assertion failed");

`endif

// ===== rtl/ts_pbe_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, constants, types and helpers of the pcr bitrate estimator
// no dependencies; used by every other rtl file but the assertion macro header
package ts_pbe_pkg;

    localparam int DATA_W     = 8;
    localparam int PID_W      = 13;
    localparam int POS_W      = 8;
    localparam int PCR_W      = 48;
    localparam int COUNT_BITS = 24;
    localparam int PKT_W      = 24;
    localparam int TICK_W     = 42;
    localparam int RATE_W     = 40;
    localparam int BPP_W      = 11;
    localparam int TPS_W      = 25;
    localparam int MULT_W     = COUNT_BITS + BPP_W;
    localparam int NUM_W      = MULT_W + TPS_W;
    localparam int DIV_CNT_W  = $clog2(NUM_W);
    localparam int CNT_EXT_W  = (COUNT_BITS > PKT_W) ? COUNT_BITS : PKT_W;

    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_FILL_W   = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = PID_W;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_FORMAT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PCR_PID       = 1'd1;

    localparam logic [TICK_W-1:0]     PCR_PERIOD      = 42'd2576980377600;
    localparam logic [TICK_W-1:0]     PCR_BASE_MUL    = 42'd300;
    localparam logic [BPP_W-1:0]      BITS_PER_PACKET = 11'd1504;
    localparam logic [TPS_W-1:0]      TICKS_PER_SEC   = 25'd27000000;
    localparam logic [RATE_W-1:0]     RATE_MAX        = {RATE_W{1'b1}};
    localparam logic [PKT_W-1:0]      PKT_MAX         = {PKT_W{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX       = {COUNT_BITS{1'b1}};

    // byte positions inside a packet, counted after any timecode prefix
    localparam logic [POS_W-1:0] POS_LAST   = 8'd255;
    localparam logic [POS_W-1:0] PREFIX_LEN = 8'd4;
    localparam logic [POS_W-1:0] T_PID_HI   = 8'd1;
    localparam logic [POS_W-1:0] T_PID_LO   = 8'd2;
    localparam logic [POS_W-1:0] T_ADAPT    = 8'd3;
    localparam logic [POS_W-1:0] T_FLAGS    = 8'd5;
    localparam logic [POS_W-1:0] T_PCR0     = 8'd6;
    localparam logic [POS_W-1:0] T_PCR1     = 8'd7;
    localparam logic [POS_W-1:0] T_PCR2     = 8'd8;
    localparam logic [POS_W-1:0] T_PCR3     = 8'd9;
    localparam logic [POS_W-1:0] T_PCR4     = 8'd10;
    localparam logic [POS_W-1:0] T_PCR5     = 8'd11;

    typedef struct packed {
        logic             packet_format;
        logic [PID_W-1:0] pcr_pid;
    } t_cfg;

    typedef struct packed {
        logic [PCR_W-1:0]      pcr_bytes;
        logic [COUNT_BITS-1:0] count;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICKS,
        ST_DIFF,
        ST_DIV,
        ST_DONE
    } t_back_state;

    function automatic logic [PKT_W-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
        logic [CNT_EXT_W-1:0] w;
        w = CNT_EXT_W'(c);
        if (w > CNT_EXT_W'(PKT_MAX)) begin
            return PKT_MAX;
        end
        return PKT_W'(w);
    endfunction

endpackage

// ===== rtl/ts_pbe_in_if.sv =====
`timescale 1ns / 1ps
// input byte channel of the pcr bitrate estimator
// depends on ts_pbe_pkg
interface ts_pbe_in_if;
    import ts_pbe_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              packet_start;

    modport source (output valid, data_byte, packet_start, input ready);
    modport sink   (input valid, data_byte, packet_start, output ready);
endinterface

// ===== rtl/ts_pbe_out_if.sv =====
`timescale 1ns / 1ps
// result channel of the pcr bitrate estimator
// depends on ts_pbe_pkg
interface ts_pbe_out_if;
    import ts_pbe_pkg::*;

    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] pcr_ticks;
    logic [PKT_W-1:0]  packets_between;
    logic [TICK_W-1:0] pcr_diff_ticks;
    logic [RATE_W-1:0] bitrate_bps;
    logic              bitrate_valid;

    modport source (output valid, pcr_ticks, packets_between, pcr_diff_ticks,
                    bitrate_bps, bitrate_valid, input ready);
    modport sink   (input valid, pcr_ticks, packets_between, pcr_diff_ticks,
                    bitrate_bps, bitrate_valid, output ready);
endinterface

// ===== rtl/ts_pbe_front.sv =====
`timescale 1ns / 1ps
// front end: walks packet headers byte by byte, counts packets, queues pcr jobs
// depends on ts_pbe_pkg and ts_pbe_in_if
module ts_pbe_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ts_pbe_pkg::t_cfg    i_cfg,
    ts_pbe_in_if.sink           i_in,
    input  logic                i_q_full,
    output logic                o_push,
    output ts_pbe_pkg::t_job    o_job
);
    import ts_pbe_pkg::*;

    logic [POS_W-1:0]      r_pos,       n_pos;
    logic [PID_W-1:0]      r_pid,       n_pid;
    logic                  r_adapt,     n_adapt;
    logic                  r_pcrf,      n_pcrf;
    logic [PCR_W-1:0]      r_pcr_bytes, n_pcr_bytes;
    logic [COUNT_BITS-1:0] r_count,     n_count;

    logic             accept;
    logic             active;
    logic [POS_W-1:0] idx;
    logic [POS_W-1:0] off;
    logic [POS_W-1:0] t;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_pos       = r_pos;
        n_pid       = r_pid;
        n_adapt     = r_adapt;
        n_pcrf      = r_pcrf;
        n_pcr_bytes = r_pcr_bytes;
        n_count     = r_count;
        active      = 1'b0;
        idx         = '0;
        t           = '0;
        o_push      = 1'b0;

        if (accept) begin
            if (i_in.packet_start) begin
                active      = 1'b1;
                n_pos       = POS_W'(1);
                n_pid       = '0;
                n_adapt     = 1'b0;
                n_pcrf      = 1'b0;
                n_pcr_bytes = '0;
                if (r_count != COUNT_MAX) begin
                    n_count = r_count + 1'b1;
                end
            end else if (r_pos != '0 && r_pos != POS_LAST) begin
                active = 1'b1;
                idx    = r_pos;
                n_pos  = r_pos + 1'b1;
            end
        end

        off = i_cfg.packet_format ? PREFIX_LEN : '0;

        if (active && idx >= off) begin
            t = idx - off;
            case (t)
                T_PID_HI: begin
                    n_pid = {i_in.data_byte[4:0], 8'h00};
                end
                T_PID_LO: begin
                    n_pid = r_pid | PID_W'(i_in.data_byte);
                end
                T_ADAPT: begin
                    n_adapt = i_in.data_byte[5];
                end
                T_FLAGS: begin
                    n_pcrf = i_in.data_byte[4];
                end
                T_PCR0, T_PCR1, T_PCR2, T_PCR3, T_PCR4: begin
                    n_pcr_bytes = {r_pcr_bytes[PCR_W-DATA_W-1:0], i_in.data_byte};
                end
                T_PCR5: begin
                    n_pcr_bytes = {r_pcr_bytes[PCR_W-DATA_W-1:0], i_in.data_byte};
                    if (r_pid == i_cfg.pcr_pid && r_adapt && r_pcrf) begin
                        o_push  = 1'b1;
                        n_count = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        o_job.pcr_bytes = n_pcr_bytes;
        o_job.count     = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_pid       <= '0;
            r_adapt     <= 1'b0;
            r_pcrf      <= 1'b0;
            r_pcr_bytes <= '0;
            r_count     <= '0;
        end else begin
            r_pos       <= n_pos;
            r_pid       <= n_pid;
            r_adapt     <= n_adapt;
            r_pcrf      <= n_pcrf;
            r_pcr_bytes <= n_pcr_bytes;
            r_count     <= n_count;
        end
    end

endmodule

// ===== rtl/ts_pbe_queue.sv =====
`timescale 1ns / 1ps
// short job queue between the header front end and the bitrate back end
// depends on ts_pbe_pkg and the assertion macro header
`include "ts_pcr_bitrate_estimator_core_macros.svh"
module ts_pbe_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ts_pbe_pkg::t_job i_job,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_not_empty,
    output ts_pbe_pkg::t_job o_job
);
    import ts_pbe_pkg::*;

    t_job                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_FILL_W-1:0] r_fill;

    assign o_full      = (r_fill == Q_FILL_W'(Q_DEPTH));
    assign o_not_empty = (r_fill != '0);
    assign o_job       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    `TS_PBE_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `TS_PBE_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, o_not_empty)
    `TS_PBE_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= Q_FILL_W'(Q_DEPTH))

endmodule

// ===== rtl/ts_pbe_back.sv =====
`timescale 1ns / 1ps
// back end: pcr ticks, wrapped difference and a bit-serial bitrate divider
// depends on ts_pbe_pkg, ts_pbe_out_if and the assertion macro header
`include "ts_pcr_bitrate_estimator_core_macros.svh"
module ts_pbe_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_not_empty,
    input  ts_pbe_pkg::t_job i_job,
    output logic             o_pop,
    ts_pbe_out_if.source     o_out
);
    import ts_pbe_pkg::*;

    t_back_state r_state, n_state;

    t_job                  r_job;
    logic [TICK_W-1:0]     r_ticks;
    logic [MULT_W-1:0]     r_mult;
    logic [TICK_W-1:0]     r_diff;
    logic                  r_valid;
    logic [NUM_W-1:0]      r_num;
    logic [TICK_W-1:0]     r_rem;
    logic [NUM_W-1:0]      r_quot;
    logic [DIV_CNT_W-1:0]  r_step;
    logic [TICK_W-1:0]     r_last_pcr;
    logic                  r_seen;

    logic                  r_out_valid;
    logic [TICK_W-1:0]     r_pcr_ticks;
    logic [PKT_W-1:0]      r_packets;
    logic [TICK_W-1:0]     r_pcr_diff;
    logic [RATE_W-1:0]     r_rate;
    logic                  r_rate_valid;

    logic                  out_load;
    logic [TICK_W-1:0]     ticks_raw;
    logic [TICK_W-1:0]     ticks_calc;
    logic [TICK_W-1:0]     diff_calc;
    logic                  div_go;
    logic [TICK_W:0]       rem_sh;
    logic                  rem_ge;
    logic [TICK_W-1:0]     rem_next;
    logic [RATE_W-1:0]     rate_sat;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_not_empty) begin
                    n_state = ST_TICKS;
                end
            end
            ST_TICKS: begin
                n_state = ST_DIFF;
            end
            ST_DIFF: begin
                n_state = div_go ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (r_step == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_pop    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_pop = i_q_not_empty;
            end
            ST_DONE: begin
                out_load = !r_out_valid || o_out.ready;
            end
            default: begin
            end
        endcase
    end

    // base * 300 + extension, folded once into the pcr period
    always_comb begin
        ticks_raw  = TICK_W'(r_job.pcr_bytes[PCR_W-1:15]) * PCR_BASE_MUL
                   + TICK_W'(r_job.pcr_bytes[8:0]);
        ticks_calc = (ticks_raw >= PCR_PERIOD) ? ticks_raw - PCR_PERIOD : ticks_raw;
    end

    always_comb begin
        if (r_ticks >= r_last_pcr) begin
            diff_calc = r_ticks - r_last_pcr;
        end else begin
            diff_calc = r_ticks + PCR_PERIOD - r_last_pcr;
        end
        div_go = r_seen && (diff_calc != '0);
    end

    // one quotient bit per cycle, msb first
    always_comb begin
        rem_sh   = {r_rem, r_num[NUM_W-1]};
        rem_ge   = (rem_sh >= {1'b0, r_diff});
        rem_next = rem_ge ? TICK_W'(rem_sh - {1'b0, r_diff}) : rem_sh[TICK_W-1:0];
        rate_sat = (r_quot[NUM_W-1:RATE_W] != '0) ? RATE_MAX : r_quot[RATE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    r_job <= i_job;
                end
            end
            ST_TICKS: begin
                r_ticks <= ticks_calc;
                r_mult  <= MULT_W'(r_job.count) * MULT_W'(BITS_PER_PACKET);
            end
            ST_DIFF: begin
                r_diff  <= div_go ? diff_calc : '0;
                r_valid <= div_go;
                r_num   <= NUM_W'(r_mult) * NUM_W'(TICKS_PER_SEC);
                r_rem   <= '0;
                r_quot  <= '0;
                r_step  <= DIV_CNT_W'(NUM_W - 1);
            end
            ST_DIV: begin
                r_rem  <= rem_next;
                r_quot <= {r_quot[NUM_W-2:0], rem_ge};
                r_num  <= {r_num[NUM_W-2:0], 1'b0};
                r_step <= r_step - 1'b1;
            end
            ST_DONE: begin
                if (out_load) begin
                    r_pcr_ticks  <= r_ticks;
                    r_packets    <= sat_count(r_job.count);
                    r_pcr_diff   <= r_diff;
                    r_rate       <= r_valid ? rate_sat : '0;
                    r_rate_valid <= r_valid;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_last_pcr  <= '0;
            r_seen      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_DIFF) begin
                r_last_pcr <= r_ticks;
                r_seen     <= 1'b1;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.pcr_ticks       = r_pcr_ticks;
    assign o_out.packets_between = r_packets;
    assign o_out.pcr_diff_ticks  = r_pcr_diff;
    assign o_out.bitrate_bps     = r_rate;
    assign o_out.bitrate_valid   = r_rate_valid;

    `TS_PBE_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, r_state == ST_DIV, r_diff != '0)
    `TS_PBE_ASSERT_IMP(a_rem_below, i_clk, i_rst_n, r_state == ST_DIV, r_rem < r_diff)
    `TS_PBE_ASSERT_NXT(a_seen_after_diff, i_clk, i_rst_n, r_state == ST_DIFF, r_seen)

endmodule

// ===== rtl/ts_pcr_bitrate_estimator_core.sv =====
`timescale 1ns / 1ps
// top level of the transport stream pcr bitrate estimator
// depends on ts_pbe_pkg, both channel interfaces, front, queue and back
//
//  channel   direction  payload                                        handshake
//  i_in      sink       data_byte, packet_start                        valid/ready
//  o_out     source     pcr_ticks, packets_between, pcr_diff_ticks,    valid/ready
//                       bitrate_bps, bitrate_valid
//  i_cfg_*   write      i_cfg_index, i_cfg_data                        i_cfg_we
//
// bytes are taken one per cycle while the two-entry job queue has room
// a pcr result with a previous pcr and a nonzero difference passes ST_TICKS, ST_DIFF,
// ST_DIV and ST_DONE in the back end, the bit-serial divider producing one quotient
// bit per cycle; a result with no division goes from ST_DIFF straight to ST_DONE
// synchronous active-low reset clears all control state and the pcr history
// a stalled result holds the back end, the queue then fills and input ready drops
module ts_pcr_bitrate_estimator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ts_pbe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ts_pbe_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ts_pbe_in_if.sink                           i_in,
    ts_pbe_out_if.source                        o_out
);
    import ts_pbe_pkg::*;

    logic             r_packet_format;
    logic [PID_W-1:0] r_pcr_pid;

    t_cfg cfg;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_not_empty;
    t_job push_job;
    t_job head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_format <= 1'b0;
            r_pcr_pid       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PACKET_FORMAT: r_packet_format <= i_cfg_data[0];
                CFG_PCR_PID:       r_pcr_pid       <= i_cfg_data[PID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.packet_format = r_packet_format;
    assign cfg.pcr_pid       = r_pcr_pid;

    ts_pbe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (push_job)
    );

    ts_pbe_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_job       (push_job),
        .i_pop       (q_pop),
        .o_full      (q_full),
        .o_not_empty (q_not_empty),
        .o_job       (head_job)
    );

    ts_pbe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_job         (head_job),
        .o_pop         (q_pop),
        .o_out         (o_out)
    );

endmodule
